// ===== rtl/lrws_pkg.sv =====
// ----------------------------------------------------------------------------
// lrws_pkg
// Types and constants shared by the LED register write sequencer.
// ----------------------------------------------------------------------------
package lrws_pkg;

  localparam int unsigned TGT_W = 3;

  localparam logic [7:0] BASE_ADDR    = 8'hc0;
  localparam logic [7:0] REG_TRANSFER = 8'h08;
  localparam logic [7:0] VAL_BEGIN    = 8'h53;
  localparam logic [7:0] VAL_END      = 8'h44;
  localparam logic [7:0] REG_MODE     = 8'h09;
  localparam logic [7:0] REG_BRIGHT   = 8'h20;
  localparam logic [7:0] REG_CMODE    = 8'h30;
  localparam logic [7:0] REG_RED      = 8'h31;
  localparam logic [7:0] REG_GREEN    = 8'h32;
  localparam logic [7:0] REG_BLUE     = 8'h33;
  localparam logic [5:0] LONG_DELAY   = 6'd50;
  localparam logic [5:0] SHORT_DELAY  = 6'd5;

  localparam logic KIND_OFF    = 1'b0;
  localparam logic KIND_STATIC = 1'b1;

  typedef struct packed {
    logic       kind;
    logic       all_modules;
    logic [7:0] module_address;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
  } cmd_t;

  typedef struct packed {
    logic [7:0] bus_address;
    logic [7:0] register_index;
    logic [7:0] write_value;
    logic [5:0] settle_ms;
    logic       status;
    logic       last;
  } wr_t;

  typedef struct packed {
    logic             kind;
    logic             err;
    logic [7:0]       addr;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       brightness;
    logic [TGT_W-1:0] tgt_first;
    logic [TGT_W-1:0] tgt_last;
  } desc_t;

endpackage

// ===== rtl/lrws_fifo.sv =====
// ----------------------------------------------------------------------------
// lrws_fifo
// Small show-ahead queue of registers.
// ----------------------------------------------------------------------------
module lrws_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/lrws_front.sv =====
// ----------------------------------------------------------------------------
// lrws_front
// Classifies a command: resolves the target range or flags a bad address.
// ----------------------------------------------------------------------------
module lrws_front #(
  parameter int unsigned MODULE_COUNT = 4
) (
  input  lrws_pkg::cmd_t  cmd_i,
  output lrws_pkg::desc_t desc_o
);

  logic [lrws_pkg::TGT_W-1:0] idx;
  logic                       addr_ok;

  assign idx     = cmd_i.module_address[lrws_pkg::TGT_W:1];
  assign addr_ok = (cmd_i.module_address[7:4] == lrws_pkg::BASE_ADDR[7:4])
                && !cmd_i.module_address[0]
                && (int'(idx) < MODULE_COUNT);

  always_comb begin
    desc_o.kind       = cmd_i.kind;
    desc_o.addr       = cmd_i.module_address;
    desc_o.red        = cmd_i.red;
    desc_o.green      = cmd_i.green;
    desc_o.blue       = cmd_i.blue;
    desc_o.brightness = cmd_i.brightness;
    if (cmd_i.all_modules) begin
      desc_o.err       = 1'b0;
      desc_o.tgt_first = '0;
      desc_o.tgt_last  = lrws_pkg::TGT_W'(MODULE_COUNT - 1);
    end else begin
      desc_o.err       = !addr_ok;
      desc_o.tgt_first = idx;
      desc_o.tgt_last  = idx;
    end
  end

endmodule

// ===== rtl/lrws_back.sv =====
// ----------------------------------------------------------------------------
// lrws_back
// Expands the queued command into writes, one per cycle while not wr_full_i.
// ----------------------------------------------------------------------------
module lrws_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lrws_pkg::desc_t desc_i,
  input  logic            desc_empty_i,
  output logic            desc_pop_o,
  output lrws_pkg::wr_t   wr_o,
  output logic            wr_push_o,
  input  logic            wr_full_i
);

  localparam logic [1:0] PH_BEGIN = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  localparam logic [2:0] ST_MODE   = 3'd0;
  localparam logic [2:0] ST_BRIGHT = 3'd1;
  localparam logic [2:0] ST_CMODE  = 3'd2;
  localparam logic [2:0] ST_RED    = 3'd3;
  localparam logic [2:0] ST_GREEN  = 3'd4;
  localparam logic [2:0] ST_BLUE   = 3'd5;

  logic [1:0]                 phase_q, phase_d;
  logic [lrws_pkg::TGT_W-1:0] cnt_q, cnt_d, tgt;
  logic [2:0]                 step_q, step_d;
  logic                       emit, done, body_tgt_done;

  assign emit      = !desc_empty_i && !wr_full_i;
  assign wr_push_o = emit;
  assign desc_pop_o = emit && done;

  always_comb begin
    tgt           = desc_i.tgt_first + cnt_q;
    wr_o          = '0;
    done          = 1'b0;
    body_tgt_done = (desc_i.kind == lrws_pkg::KIND_OFF) || (step_q == ST_BLUE);
    if (desc_i.err) begin
      wr_o.bus_address = desc_i.addr;
      wr_o.status      = 1'b1;
      wr_o.last        = 1'b1;
      done             = 1'b1;
    end else begin
      unique case (phase_q)
        PH_BEGIN: begin
          tgt                 = desc_i.tgt_last - cnt_q;
          wr_o.register_index = lrws_pkg::REG_TRANSFER;
          wr_o.write_value    = lrws_pkg::VAL_BEGIN;
          wr_o.settle_ms      = lrws_pkg::LONG_DELAY;
        end
        PH_BODY: begin
          wr_o.settle_ms = lrws_pkg::SHORT_DELAY;
          if (desc_i.kind == lrws_pkg::KIND_OFF) begin
            wr_o.register_index = lrws_pkg::REG_BRIGHT;
          end else begin
            unique case (step_q)
              ST_MODE: wr_o.register_index = lrws_pkg::REG_MODE;
              ST_BRIGHT: begin
                wr_o.register_index = lrws_pkg::REG_BRIGHT;
                wr_o.write_value    = desc_i.brightness;
              end
              ST_CMODE: begin
                wr_o.register_index = lrws_pkg::REG_CMODE;
                wr_o.write_value    = 8'h01;
              end
              ST_RED: begin
                wr_o.register_index = lrws_pkg::REG_RED;
                wr_o.write_value    = desc_i.red;
              end
              ST_GREEN: begin
                wr_o.register_index = lrws_pkg::REG_GREEN;
                wr_o.write_value    = desc_i.green;
              end
              default: begin
                wr_o.register_index = lrws_pkg::REG_BLUE;
                wr_o.write_value    = desc_i.blue;
              end
            endcase
          end
        end
        default: begin
          wr_o.register_index = lrws_pkg::REG_TRANSFER;
          wr_o.write_value    = lrws_pkg::VAL_END;
          wr_o.settle_ms      = lrws_pkg::LONG_DELAY;
          done                = (tgt == desc_i.tgt_last);
          wr_o.last           = done;
        end
      endcase
      wr_o.bus_address = lrws_pkg::BASE_ADDR | {4'h0, tgt, 1'b0};
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    if (emit) begin
      if (done) begin
        phase_d = PH_BEGIN;
        cnt_d   = '0;
        step_d  = ST_MODE;
      end else begin
        unique case (phase_q)
          PH_BEGIN: begin
            if (tgt == desc_i.tgt_first) begin
              phase_d = PH_BODY;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_q + lrws_pkg::TGT_W'(1);
            end
          end
          PH_BODY: begin
            if (body_tgt_done) begin
              step_d = ST_MODE;
              if (tgt == desc_i.tgt_last) begin
                phase_d = PH_END;
                cnt_d   = '0;
              end else begin
                cnt_d = cnt_q + lrws_pkg::TGT_W'(1);
              end
            end else begin
              step_d = step_q + 3'd1;
            end
          end
          default: cnt_d = cnt_q + lrws_pkg::TGT_W'(1);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEGIN;
      cnt_q   <= '0;
      step_q  <= ST_MODE;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== rtl/led_register_write_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// led_register_write_sequencer_core
// Turns lighting commands into ordered LED controller register writes.
// ----------------------------------------------------------------------------
// With the sequencer idle, a command's first write passes through the command
// queue and then the write queue before it is visible at wr_o.
// Throughput: one write per cycle from the sequencer while the write queue has
// room; a command has 1 write for a bad address, 3*N off, 8*N static (N targets).
// A two-entry command queue lets new commands in while the sequencer runs.
// Reset: asynchronous, active low; clears both queues and the sequencer.
module led_register_write_sequencer_core #(
  parameter int unsigned MODULE_COUNT = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  lrws_pkg::cmd_t cmd_i,
  output logic           empty,
  input  logic           pop,
  output lrws_pkg::wr_t  wr_o
);

  localparam int unsigned DESC_W = $bits(lrws_pkg::desc_t);
  localparam int unsigned WR_W   = $bits(lrws_pkg::wr_t);

  lrws_pkg::desc_t desc_in, desc_head;
  lrws_pkg::wr_t   wr_gen;
  logic [DESC_W-1:0] desc_rdata;
  logic [WR_W-1:0]   wr_rdata;
  logic            desc_empty, desc_pop, wr_push, wr_full;

  lrws_front #(
    .MODULE_COUNT(MODULE_COUNT)
  ) u_front (
    .cmd_i (cmd_i),
    .desc_o(desc_in)
  );

  lrws_fifo #(
    .WIDTH(DESC_W),
    .DEPTH(2)
  ) u_desc_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(desc_in),
    .full_o (full),
    .pop_i  (desc_pop),
    .rdata_o(desc_rdata),
    .empty_o(desc_empty)
  );

  assign desc_head = lrws_pkg::desc_t'(desc_rdata);

  lrws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc_head),
    .desc_empty_i(desc_empty),
    .desc_pop_o  (desc_pop),
    .wr_o        (wr_gen),
    .wr_push_o   (wr_push),
    .wr_full_i   (wr_full)
  );

  lrws_fifo #(
    .WIDTH(WR_W),
    .DEPTH(2)
  ) u_wr_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (wr_push),
    .wdata_i(wr_gen),
    .full_o (wr_full),
    .pop_i  (pop),
    .rdata_o(wr_rdata),
    .empty_o(empty)
  );

  assign wr_o = lrws_pkg::wr_t'(wr_rdata);

endmodule
